### rtl/servo_reply_parser_map_update_macros.svh
// ----------------------------------------------------------------------------
// Servo reply parser assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_PARSER_MAP_UPDATE_MACROS_SVH
`define SERVO_REPLY_PARSER_MAP_UPDATE_MACROS_SVH

// same-cycle implication
`define SRPM_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define SRPM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/srpm_pkg.sv
// ----------------------------------------------------------------------------
// srpm_pkg
// Shared types, constants and helpers of the servo reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srpm_pkg;

  localparam int unsigned MAX_SERVOS_DEF = 32;
  localparam int unsigned BUF_BYTES_DEF  = 64;

  localparam logic [7:0] HDR_A = 8'hFD;
  localparam logic [7:0] HDR_B = 8'hDF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_RANGE   = 2'd3
  } srpm_status_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [7:0] read_servo;
    logic [5:0] read_address;
  } srpm_in_item_t;

  typedef struct packed {
    logic       packet_done;
    logic [1:0] packet_status;
    logic [7:0] packet_servo;
    logic [7:0] packet_flag;
    logic [7:0] packet_address;
    logic [7:0] packet_length;
    logic [7:0] read_data;
  } srpm_out_item_t;

  // parser view of the current packet
  typedef struct packed {
    logic         hit;
    srpm_status_e status;
    logic [7:0]   servo;
    logic [7:0]   flag;
    logic [7:0]   address;
    logic [7:0]   length;
  } srpm_pkt_t;

  function automatic logic srpm_servo_known(input logic [7:0]  id,
                                            input logic [31:0] mask,
                                            input logic [7:0]  max_servos);
    logic [7:0] idx;
    idx = id - 8'd1;
    return (id != 8'd0) && (id <= max_servos) && (id <= 8'd32) && mask[idx[4:0]];
  endfunction

endpackage

`default_nettype wire

### rtl/servo_reply_parser_map_update.sv
// Line byte: the result is loaded into the output register from S_DONE; input stalls until S_IDLE.
// Read command: the sequencer steps through S_RADDR and S_RDATA (map read registered) to S_DONE.
// Packet copy: on a checksum byte with status OK, one map byte is written per cycle.
// After reset all MAX_SERVOS * BUF_BYTES map entries (2048 by default) are cleared.
// ----------------------------------------------------------------------------
// servo_reply_parser_map_update
// Reply packet parser with XOR checksum that updates per-servo memory maps,
// sequenced over one shared map address unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_reply_parser_map_update_macros.svh"

module servo_reply_parser_map_update
  import srpm_pkg::*;
#(
  parameter int unsigned MAX_SERVOS = MAX_SERVOS_DEF,
  parameter int unsigned BUF_BYTES  = BUF_BYTES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           servo_enable_mask_we_i,
  input  wire logic [31:0]    servo_enable_mask_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire srpm_in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output srpm_out_item_t      out_item_o
);

  localparam int unsigned MAP_DEPTH = MAX_SERVOS * BUF_BYTES;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned PS_AW     = $clog2(BUF_BYTES);
  localparam int unsigned SV_W      = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
  localparam int unsigned UW        = MAP_AW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RADDR = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [31:0]     mask_q;
  srpm_in_item_t   item_q, item_d;
  logic            known_q, known_d;
  srpm_out_item_t  res_q, res_d;
  logic [PS_AW-1:0] rd_cnt_q, rd_cnt_d;
  logic            wr_v_q, wr_v_d;
  logic [MAP_AW-1:0] wr_addr_q, wr_addr_d;
  logic            out_valid_q;
  srpm_out_item_t  out_q;

  logic            accept;
  logic            byte_v;
  srpm_pkt_t       pkt;
  logic [7:0]      ps_rdata;
  logic [7:0]      map_rdata;
  logic            map_busy;
  logic            out_load;

  // shared map address unit
  logic [7:0]        unit_id;
  logic [8:0]        unit_off;
  logic [SV_W-1:0]   unit_idx;
  logic [UW-1:0]     unit_full;
  logic [MAP_AW-1:0] unit_addr;

  assign accept = in_valid_i & ~in_stall_o;
  assign byte_v = accept & ~in_item_i.cmd;

  assign in_stall_o = (state_q != S_IDLE) | map_busy;

  assign unit_id   = (state_q == S_COPY) ? pkt.servo : item_q.read_servo;
  assign unit_off  = (state_q == S_COPY) ? (9'(pkt.address) + 9'(rd_cnt_q))
                                         : 9'(item_q.read_address);
  assign unit_idx  = SV_W'(unit_id - 8'd1);
  assign unit_full = UW'(unit_idx) * UW'(BUF_BYTES) + UW'(unit_off);
  assign unit_addr = unit_full[MAP_AW-1:0];

  srpm_parse #(
    .MAX_SERVOS (MAX_SERVOS),
    .BUF_BYTES  (BUF_BYTES),
    .PS_AW      (PS_AW)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_v_i   (byte_v),
    .byte_i     (in_item_i.rx_byte),
    .mask_i     (mask_q),
    .ps_raddr_i (rd_cnt_q),
    .ps_rdata_o (ps_rdata),
    .pkt_o      (pkt)
  );

  srpm_map #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAP_AW)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_v_q),
    .waddr_i (wr_addr_q),
    .wdata_i (ps_rdata),
    .raddr_i (unit_addr),
    .rdata_o (map_rdata),
    .busy_o  (map_busy)
  );

  assign out_load = (state_q == S_DONE) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    known_d   = known_q;
    res_d     = res_q;
    rd_cnt_d  = rd_cnt_q;
    wr_v_d    = 1'b0;
    wr_addr_d = wr_addr_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d  = in_item_i;
          known_d = srpm_servo_known(in_item_i.read_servo, mask_q, 8'(MAX_SERVOS)) &&
                    (9'(in_item_i.read_address) < 9'(BUF_BYTES));
          res_d    = '0;
          rd_cnt_d = '0;
          if (in_item_i.cmd) begin
            state_d = S_RADDR;
          end else if (pkt.hit) begin
            res_d.packet_done    = 1'b1;
            res_d.packet_status  = pkt.status;
            res_d.packet_servo   = pkt.servo;
            res_d.packet_flag    = pkt.flag;
            res_d.packet_address = pkt.address;
            res_d.packet_length  = pkt.length;
            state_d = (pkt.status == ST_OK) ? S_COPY : S_DONE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RADDR: begin
        state_d = S_RDATA;
      end
      S_RDATA: begin
        res_d.read_data = known_q ? map_rdata : 8'd0;
        state_d = S_DONE;
      end
      S_COPY: begin
        if (rd_cnt_q != pkt.length[PS_AW-1:0]) begin
          wr_v_d    = 1'b1;
          wr_addr_d = unit_addr;
          rd_cnt_d  = rd_cnt_q + PS_AW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= 32'd0;
      wr_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_v_q  <= wr_v_d;
      if (servo_enable_mask_we_i) mask_q <= servo_enable_mask_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    known_q   <= known_d;
    res_q     <= res_d;
    rd_cnt_q  <= rd_cnt_d;
    wr_addr_q <= wr_addr_d;
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SRPM_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "item accepted but sequencer idle")
  `SRPM_ASSERT_SAME(a_wr_in_copy, wr_v_q, state_q == S_COPY, "map write outside copy")
  `SRPM_ASSERT_NEXT(a_done_loads, (state_q == S_DONE) && !out_stall_i, out_valid_q && state_q == S_IDLE, "result not loaded")

endmodule

`default_nettype wire

### rtl/srpm_parse.sv
// ----------------------------------------------------------------------------
// srpm_parse
// Byte-level reply packet parser with packet store and checksum check.
// ----------------------------------------------------------------------------
`default_nettype none

module srpm_parse
  import srpm_pkg::*;
#(
  parameter int unsigned MAX_SERVOS = MAX_SERVOS_DEF,
  parameter int unsigned BUF_BYTES  = BUF_BYTES_DEF,
  parameter int unsigned PS_AW      = $clog2(BUF_BYTES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_v_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic [31:0]      mask_i,
  input  wire logic [PS_AW-1:0] ps_raddr_i,
  output logic [7:0]            ps_rdata_o,
  output srpm_pkt_t             pkt_o
);

  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_HDR2 = 4'd1;
  localparam logic [3:0] PH_ID   = 4'd2;
  localparam logic [3:0] PH_FLAG = 4'd3;
  localparam logic [3:0] PH_ADDR = 4'd4;
  localparam logic [3:0] PH_LEN  = 4'd5;
  localparam logic [3:0] PH_CNT  = 4'd6;
  localparam logic [3:0] PH_DATA = 4'd7;
  localparam logic [3:0] PH_SUM  = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic [7:0] servo_q, servo_d;
  logic [7:0] flag_q, flag_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] xor_q, xor_d;
  logic       ps_we;
  logic [8:0] end_addr;

  logic [7:0] ps_mem [BUF_BYTES];

  always_comb begin
    phase_d = phase_q;
    servo_d = servo_q;
    flag_d  = flag_q;
    addr_d  = addr_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    xor_d   = xor_q;
    ps_we   = 1'b0;
    if (byte_v_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == HDR_A) phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          if (byte_i == HDR_B) begin
            phase_d = PH_ID;
          end else if (byte_i != HDR_A) begin
            phase_d = PH_HUNT;
          end
        end
        PH_ID: begin
          servo_d = byte_i;
          xor_d   = byte_i;
          phase_d = PH_FLAG;
        end
        PH_FLAG: begin
          flag_d  = byte_i;
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_ADDR;
        end
        PH_ADDR: begin
          addr_d  = byte_i;
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = byte_i;
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_CNT;
        end
        PH_CNT: begin
          cnt_d   = byte_i;
          xor_d   = xor_q ^ byte_i;
          idx_d   = 8'd0;
          phase_d = (len_q != 8'd0) ? PH_DATA : PH_SUM;
        end
        PH_DATA: begin
          ps_we = ({1'b0, idx_q} < 9'(BUF_BYTES));
          xor_d = xor_q ^ byte_i;
          idx_d = idx_q + 8'd1;
          if (idx_q + 8'd1 == len_q) phase_d = PH_SUM;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  assign end_addr = {1'b0, addr_q} + {1'b0, len_q};

  always_comb begin
    pkt_o.hit     = (phase_q == PH_SUM);
    pkt_o.servo   = servo_q;
    pkt_o.flag    = flag_q;
    pkt_o.address = addr_q;
    pkt_o.length  = len_q;
    if (!srpm_servo_known(servo_q, mask_i, 8'(MAX_SERVOS))) begin
      pkt_o.status = ST_UNKNOWN;
    end else if (xor_q != byte_i) begin
      pkt_o.status = ST_BAD_SUM;
    end else if (end_addr >= 9'(BUF_BYTES)) begin
      pkt_o.status = ST_RANGE;
    end else begin
      pkt_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      servo_q <= 8'd0;
      flag_q  <= 8'd0;
      addr_q  <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      idx_q   <= 8'd0;
      xor_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      servo_q <= servo_d;
      flag_q  <= flag_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
    end
  end

  // packet store
  always_ff @(posedge clk_i) begin
    if (ps_we) ps_mem[idx_q[PS_AW-1:0]] <= byte_i;
    ps_rdata_o <= ps_mem[ps_raddr_i];
  end

endmodule

`default_nettype wire

### rtl/srpm_map.sv
// ----------------------------------------------------------------------------
// srpm_map
// Servo memory map store with clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module srpm_map
  import srpm_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_SERVOS_DEF * BUF_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdata_o,
  output logic               busy_o
);

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  assign mem_we    = clr_busy_q | we_i;
  assign mem_waddr = clr_busy_q ? clr_addr_q : waddr_i;
  assign mem_wdata = clr_busy_q ? 8'd0 : wdata_i;
  assign busy_o    = clr_busy_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
